// ===== hw/rtl/ctsw_pkg.sv =====
// Shared widths, constants, types and the seed table for the texel solid-angle weight block.
`default_nettype none

package ctsw_pkg;

	// Field and register widths.
	localparam int COORD_W    = 12;
	localparam int VALUE_W    = 32;
	localparam int FACE_W     = 13;
	localparam int STEP_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Largest face edge that the coordinate check honours.
	localparam int MAX_FACE_SIZE = 4096;

	// Coordinate product (2*idx+1)*step and the square of the step.
	localparam int PROD_W    = COORD_W + 1 + STEP_W;
	localparam int STEP_SQ_W = 2 * STEP_W;

	// Reciprocal square root estimate in Q.30, with one bit of headroom.
	localparam int Y_W    = 31;
	localparam int SEED_W = 30;

	// Seed table geometry: indexed by the top six bits of the normalised argument.
	localparam int SEED_DEPTH       = 64;
	localparam int SEED_IDX_W       = 6;
	localparam int SEED_SEARCH_BITS = 32;
	localparam int SEED_NUM_SHIFT   = 59;
	localparam int SEED_SCALE_SHIFT = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FACE_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXEL_STEP = 2'd1;

	// Register values after reset.
	localparam logic [FACE_W-1:0]    FACE_SIZE_RST  = 13'd64;
	localparam logic [STEP_W-1:0]    TEXEL_STEP_RST = 32'd33554432;
	localparam logic [STEP_SQ_W-1:0] STEP_SQ_RST    = 64'd1 << 50;

	// 3.0 in Q.30.
	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [FACE_W-1:0]    face_size;
		logic [STEP_W-1:0]    step;
		logic [STEP_SQ_W-1:0] step_sq;
	} cfg_t;

	// One texel in flight between the front end, the Newton steps and the scaler.
	typedef struct packed {
		logic [Y_W-1:0]     y;
		logic [31:0]        f;
		logic               e;
		logic               err;
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	typedef logic [SEED_DEPTH-1:0][SEED_W-1:0] seed_rom_t;

	// Builds the seed table once at elaboration: entry k holds
	// isqrt(floor(2^59 / (2k+1))) << 3, found as the largest root whose square
	// times (2k+1) does not pass 2^59.
	function automatic seed_rom_t build_seed_rom();
		seed_rom_t    rom;
		logic [127:0] root;
		logic [127:0] cand;
		logic [127:0] odd;
		rom = '0;
		for (int k = 0; k < SEED_DEPTH; k++) begin
			odd  = 128'(2 * k + 1);
			root = '0;
			for (int b = SEED_SEARCH_BITS - 1; b >= 0; b--) begin
				cand = root | (128'(1) << b);
				if (cand * cand * odd <= (128'(1) << SEED_NUM_SHIFT)) begin
					root = cand;
				end
			end
			rom[k] = SEED_W'(root << SEED_SCALE_SHIFT);
		end
		return rom;
	endfunction

	localparam seed_rom_t SEED_ROM = build_seed_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/ctsw_cfg.sv =====
// Configuration registers and the registered square of the texel step.
`default_nettype none

module ctsw_cfg
	import ctsw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [FACE_W-1:0]    face_size_q;
	logic [STEP_W-1:0]    step_q;
	logic [STEP_SQ_W-1:0] step_sq_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= FACE_SIZE_RST;
			step_q      <= TEXEL_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FACE_SIZE:  face_size_q <= cfg_wdata[FACE_W-1:0];
				REG_TEXEL_STEP: step_q      <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// The step squared is registered from the step register and follows it in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_sq_q <= STEP_SQ_RST;
		end else begin
			step_sq_q <= STEP_SQ_W'(step_q) * STEP_SQ_W'(step_q);
		end
	end

	assign cfg.face_size = face_size_q;
	assign cfg.step      = step_q;
	assign cfg.step_sq   = step_sq_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ctsw_front.sv =====
// Front end: coordinate check, face coordinates, squared radius and the seed lookup.
`default_nettype none

module ctsw_front
	import ctsw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_W-1:0]        texel_col,
	input  logic [COORD_W-1:0]        texel_row,
	input  logic signed [VALUE_W-1:0] sample_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output item_t                     out_item
);

	localparam logic [PROD_W-1:0] HALF_Q31 = PROD_W'(1) << 31;
	localparam logic [63:0]       ROUND_SQ = 64'd1 << 31;
	localparam logic [33:0]       ONE_Q30  = 34'd1 << 30;

	// Absolute coordinate in Q.31, saturated just under 2.0.
	function automatic logic [31:0] abs_sat(input logic [PROD_W-1:0] prod);
		logic [PROD_W-1:0] dif;
		if (prod >= HALF_Q31) begin
			dif = prod - HALF_Q31;
		end else begin
			dif = HALF_Q31 - prod;
		end
		if (dif[PROD_W-1:32] != '0) begin
			return '1;
		end
		return dif[31:0];
	endfunction

	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [PROD_W-1:0]  prod_c_s1, prod_r_s1;
	logic [31:0]        abs_c_s2, abs_r_s2;
	logic [63:0]        sq_c_s3, sq_r_s3;
	logic [33:0]        m2_s4;
	logic               err_s1, err_s2, err_s3, err_s4;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [VALUE_W-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	item_t              item_s5;

	logic [FACE_W-1:0]  lim;
	logic               err_in;
	logic [VALUE_W-1:0] val_u;
	logic [VALUE_W-1:0] mag_in;
	logic [63:0]        rnd_c, rnd_r;
	logic               e_nx;
	logic [31:0]        f_nx;
	logic [SEED_IDX_W-1:0] k_nx;

	// Stall chain: a stage moves when it is empty or its successor moves.
	assign en_s5    = !vld_s5 || out_ready;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Coordinate range check and magnitude of the sample.
	always_comb begin
		lim    = (cfg.face_size > FACE_W'(MAX_FACE_SIZE)) ? FACE_W'(MAX_FACE_SIZE)
		                                                  : cfg.face_size;
		err_in = ({1'b0, texel_col} >= lim) || ({1'b0, texel_row} >= lim);
		val_u  = sample_value;
		mag_in = val_u[VALUE_W-1] ? (~val_u + VALUE_W'(1)) : val_u;
	end

	// Rounded squares, the squared radius and its normalisation into [1.0, 4.0).
	always_comb begin
		rnd_c = sq_c_s3 + ROUND_SQ;
		rnd_r = sq_r_s3 + ROUND_SQ;
		e_nx  = (m2_s4[33:32] != 2'b00);
		f_nx  = e_nx ? m2_s4[33:2] : m2_s4[31:0];
		k_nx  = f_nx[31:26];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_c_s1 <= PROD_W'({texel_col, 1'b1}) * PROD_W'(cfg.step);
			prod_r_s1 <= PROD_W'({texel_row, 1'b1}) * PROD_W'(cfg.step);
			err_s1    <= err_in;
			neg_s1    <= val_u[VALUE_W-1];
			mag_s1    <= mag_in;
		end
		if (en_s2) begin
			abs_c_s2 <= abs_sat(prod_c_s1);
			abs_r_s2 <= abs_sat(prod_r_s1);
			err_s2   <= err_s1;
			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
		end
		if (en_s3) begin
			sq_c_s3 <= 64'(abs_c_s2) * 64'(abs_c_s2);
			sq_r_s3 <= 64'(abs_r_s2) * 64'(abs_r_s2);
			err_s3  <= err_s2;
			neg_s3  <= neg_s2;
			mag_s3  <= mag_s2;
		end
		if (en_s4) begin
			m2_s4  <= 34'(rnd_c[63:32]) + 34'(rnd_r[63:32]) + ONE_Q30;
			err_s4 <= err_s3;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
		end
		if (en_s5) begin
			item_s5.y   <= Y_W'(SEED_ROM[k_nx]);
			item_s5.f   <= f_nx;
			item_s5.e   <= e_nx;
			item_s5.err <= err_s4;
			item_s5.neg <= neg_s4;
			item_s5.mag <= mag_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_item  = item_s5;

	// The normalised argument always lies at or above 1.0.
	a_f_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (item_s5.f[31:30] != 2'b00))
		else $error("normalised argument below 1.0");

endmodule

`default_nettype wire

// ===== hw/rtl/ctsw_newton.sv =====
// One Newton step of the reciprocal square root, over three pipeline stages.
`default_nettype none

module ctsw_newton
	import ctsw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	logic en_s1, en_s2, en_s3;
	logic vld_s1, vld_s2, vld_s3;

	item_t       item_s1, item_s2, item_s3;
	logic [61:0] yy_s1;
	logic [62:0] fy_s2;
	logic [62:0] prod_s3;

	logic [30:0] y2;
	logic [32:0] u;
	logic [31:0] fac;

	// Stall chain.
	assign en_s3    = !vld_s3 || out_ready;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// y^2 truncated to Q.30, then the correction factor 3.0 - f*y^2, floored at zero.
	always_comb begin
		y2  = yy_s1[60:30];
		u   = fy_s2[62:30];
		fac = (u < 33'(THREE_Q30)) ? 32'(33'(THREE_Q30) - u) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
		end
	end

	// One multiplier per stage.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= in_item;
			yy_s1   <= 62'(in_item.y) * 62'(in_item.y);
		end
		if (en_s2) begin
			item_s2 <= item_s1;
			fy_s2   <= 63'(item_s1.f) * 63'(y2);
		end
		if (en_s3) begin
			item_s3 <= item_s2;
			prod_s3 <= 63'(item_s2.y) * 63'(fac);
		end
	end

	// The new estimate is the product halved back into Q.30.
	always_comb begin
		out_item   = item_s3;
		out_item.y = prod_s3[61:31];
	end

	assign out_valid = vld_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/ctsw_scale.sv =====
// Back end: cube of the reciprocal root, scaling by value and step squared, rounding and saturation.
`default_nettype none

module ctsw_scale
	import ctsw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  item_t                     in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] weighted_value,
	output logic                      coord_error
);

	localparam logic [62:0]  ROUND_Q30   = 63'd1 << 29;
	localparam logic [127:0] ROUND_E0    = 128'd1 << 89;
	localparam logic [127:0] ROUND_E1    = 128'd1 << 92;
	localparam logic [36:0]  MAG_POS_MAX = 37'h0_7FFF_FFFF;
	localparam logic [36:0]  MAG_NEG_MAX = 37'h0_8000_0000;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	item_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6, item_s7, item_s8;

	logic [61:0]         yy_s1;
	logic [30:0]         y2r_s2;
	logic [61:0]         r3p_s3;
	logic [30:0]         r3_s4;
	logic [62:0]         q_s5;
	logic [63:0]         pp00_s6, pp10_s6;
	logic [62:0]         pp01_s6, pp11_s6;
	logic [126:0]        p_s7;
	logic [36:0]         rnd_s8;
	logic [VALUE_W-1:0]  wv_s9;
	logic                err_s9;
	logic                neg_s9;

	logic [62:0]        yy_rnd;
	logic [62:0]        r3_rnd;
	logic [127:0]       p_rnd;
	logic [36:0]        rnd_nx;
	logic [36:0]        mag_sat;
	logic [VALUE_W-1:0] wv_nx;

	// Stall chain.
	assign en_s9    = !vld_s9 || out_ready;
	assign en_s8    = !vld_s8 || en_s9;
	assign en_s7    = !vld_s7 || en_s8;
	assign en_s6    = !vld_s6 || en_s7;
	assign en_s5    = !vld_s5 || en_s6;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s3    = !vld_s3 || en_s4;
	assign en_s2    = !vld_s2 || en_s3;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Rounding of the cube products, half up at bit 30.
	always_comb begin
		yy_rnd = 63'(yy_s1) + ROUND_Q30;
		r3_rnd = 63'(r3p_s3) + ROUND_Q30;
	end

	// Final scale 2^-90, or 2^-93 when the radius was normalised, rounded half up.
	always_comb begin
		p_rnd  = 128'(p_s7) + (item_s7.e ? ROUND_E1 : ROUND_E0);
		rnd_nx = item_s7.e ? 37'(p_rnd >> 93) : 37'(p_rnd >> 90);
	end

	// Saturation to Q16.16, sign restored; a texel off the face gives zero.
	always_comb begin
		mag_sat = '0;
		wv_nx   = '0;
		if (!item_s8.err) begin
			if (item_s8.neg) begin
				mag_sat = (rnd_s8 > MAG_NEG_MAX) ? MAG_NEG_MAX : rnd_s8;
				wv_nx   = ~mag_sat[VALUE_W-1:0] + VALUE_W'(1);
			end else begin
				mag_sat = (rnd_s8 > MAG_POS_MAX) ? MAG_POS_MAX : rnd_s8;
				wv_nx   = mag_sat[VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	// Datapath stages: cube, value product, 64 by 63 bit product in four parts, sum, round, saturate.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= in_item;
			yy_s1   <= 62'(in_item.y) * 62'(in_item.y);
		end
		if (en_s2) begin
			item_s2 <= item_s1;
			y2r_s2  <= yy_rnd[60:30];
		end
		if (en_s3) begin
			item_s3 <= item_s2;
			r3p_s3  <= 62'(y2r_s2) * 62'(item_s2.y);
		end
		if (en_s4) begin
			item_s4 <= item_s3;
			r3_s4   <= r3_rnd[60:30];
		end
		if (en_s5) begin
			item_s5 <= item_s4;
			q_s5    <= 63'(item_s4.mag) * 63'(r3_s4);
		end
		if (en_s6) begin
			item_s6 <= item_s5;
			pp00_s6 <= 64'(cfg.step_sq[31:0]) * 64'(q_s5[31:0]);
			pp01_s6 <= 63'(cfg.step_sq[31:0]) * 63'(q_s5[62:32]);
			pp10_s6 <= 64'(cfg.step_sq[63:32]) * 64'(q_s5[31:0]);
			pp11_s6 <= 63'(cfg.step_sq[63:32]) * 63'(q_s5[62:32]);
		end
		if (en_s7) begin
			item_s7 <= item_s6;
			p_s7    <= (127'(pp11_s6) << 64) + (127'(pp01_s6) << 32)
			         + (127'(pp10_s6) << 32) + 127'(pp00_s6);
		end
		if (en_s8) begin
			item_s8 <= item_s7;
			rnd_s8  <= rnd_nx;
		end
		if (en_s9) begin
			wv_s9  <= wv_nx;
			err_s9 <= item_s8.err;
			neg_s9 <= item_s8.neg;
		end
	end

	assign out_valid      = vld_s9;
	assign weighted_value = wv_s9;
	assign coord_error    = err_s9;

	// A flagged texel leaves as zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && err_s9 |-> (wv_s9 == '0))
		else $error("coordinate error with non-zero result");

	// A non-zero result keeps the sign of the sample after saturation.
	a_sign_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !err_s9 && (wv_s9 != '0) |-> (wv_s9[VALUE_W-1] == neg_s9))
		else $error("result sign differs from sample sign");

endmodule

`default_nettype wire

// ===== hw/rtl/cubemap_texel_solid_angle_weight.sv =====
// Top level of the cubemap texel solid-angle weight block.
`default_nettype none

// Weights one cube-face texel value by the solid angle of its texel,
// step^2 * (x^2 + y^2 + 1)^-1.5, and returns the product rounded to nearest and
// saturated to Q16.16. The block is a 20-stage pipeline that takes one
// transaction per cycle unless stalled: five stages form the coordinates, the
// squared radius and a table seed, two Newton steps of three stages each refine
// the reciprocal square root, and nine stages form the cube, scale by the value
// and the squared step, round and saturate. Each stage moves whenever it is
// empty or its successor moves, so back-pressure on the result side fills bubbles
// first and only stops new texels once all 20 stages hold one. Texels whose
// column or row is not below face_size leave with coord_error set and a zero
// value. Registers are written by the user only while the pipeline is empty;
// the block itself does not enforce this. The squared step is registered and
// follows a write of texel_step in the next cycle.
module cubemap_texel_solid_angle_weight
	import ctsw_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [COORD_W-1:0]        texel_col,
	input  logic [COORD_W-1:0]        texel_row,
	input  logic signed [VALUE_W-1:0] sample_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] weighted_value,
	output logic                      coord_error
);

	cfg_t  cfg;
	item_t fr_item, n1_item, n2_item;
	logic  fr_valid, fr_ready;
	logic  n1_valid, n1_ready;
	logic  n2_valid, n2_ready;

	// Registers.
	ctsw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Coordinates, radius and seed.
	ctsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.texel_col    (texel_col),
		.texel_row    (texel_row),
		.sample_value (sample_value),
		.out_valid    (fr_valid),
		.out_ready    (fr_ready),
		.out_item     (fr_item)
	);

	// First Newton step.
	ctsw_newton u_newton1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (n1_valid),
		.out_ready (n1_ready),
		.out_item  (n1_item)
	);

	// Second Newton step.
	ctsw_newton u_newton2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n1_valid),
		.in_ready  (n1_ready),
		.in_item   (n1_item),
		.out_valid (n2_valid),
		.out_ready (n2_ready),
		.out_item  (n2_item)
	);

	// Cube, scaling and saturation.
	ctsw_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (n2_valid),
		.in_ready       (n2_ready),
		.in_item        (n2_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.weighted_value (weighted_value),
		.coord_error    (coord_error)
	);

	// With the last stage empty every stage can move, so a texel is always taken.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the cubemap texel solid-angle weight block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ctsw_pkg::*;

	// Register indexes that the block does not decode; writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int PIPE_DEPTH  = 20;
	localparam int LONG_STALL  = 300;
	localparam int IDLE_PCT    = 27;
	localparam int TIMEOUT_NS  = 1_000_000;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [VALUE_W-1:0] value;
	} texel_t;

	typedef struct packed {
		logic [VALUE_W-1:0] weighted_value;
		logic               coord_error;
	} weighted_t;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      cfg_wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index      = '0;
	logic [CFG_DATA_W-1:0]     cfg_wdata      = '0;
	logic                      in_valid       = 1'b0;
	logic                      in_ready;
	logic [COORD_W-1:0]        texel_col      = '0;
	logic [COORD_W-1:0]        texel_row      = '0;
	logic signed [VALUE_W-1:0] sample_value   = '0;
	logic                      out_valid;
	logic                      out_ready      = 1'b0;
	logic signed [VALUE_W-1:0] weighted_value;
	logic                      coord_error;

	// Shadow copy of the configuration registers.
	logic [FACE_W-1:0] model_face = FACE_SIZE_RST;
	logic [STEP_W-1:0] model_step = TEXEL_STEP_RST;

	texel_t    texel_queue[$];
	weighted_t pending_weights[$];
	logic      in_taken       = 1'b0;
	logic      idle_on        = 1'b1;
	int        mismatch_count = 0;
	int        stall_requests = 0;
	int        stall_served   = 0;
	int        stall_left     = 0;

	cubemap_texel_solid_angle_weight uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.texel_col      (texel_col),
		.texel_row      (texel_row),
		.sample_value   (sample_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.weighted_value (weighted_value),
		.coord_error    (coord_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer square root, rounded down.
	function automatic logic [63:0] isqrt_floor(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		rem  = v;
		root = '0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - root - bitv;
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Square of one face coordinate in Q.30; the magnitude saturates just under 2.0.
	function automatic logic [63:0] coord_square(input logic [COORD_W-1:0] idx,
		input logic [STEP_W-1:0] step);
		logic signed [63:0] d;
		logic [63:0]        a;
		d = $signed({51'd0, idx, 1'b1} * {32'd0, step}) - 64'sd2147483648;
		a = (d < 0) ? 64'(-d) : 64'(d);
		if (a > 64'hFFFF_FFFF) a = 64'hFFFF_FFFF;
		return (a * a + (64'd1 << 31)) >> 32;
	endfunction

	// One truncating Newton step towards 1/sqrt(f) in Q.30.
	function automatic logic [63:0] newton_step(input logic [63:0] y, input logic [63:0] f);
		logic [63:0] y2;
		logic [63:0] u;
		logic [63:0] fac;
		y2  = (y * y) >> 30;
		u   = (f * y2) >> 30;
		fac = (u < 64'(THREE_Q30)) ? 64'(THREE_Q30) - u : 64'd0;
		return (y * fac) >> 31;
	endfunction

	// Expected output for one texel under the given configuration.
	function automatic weighted_t weigh_texel(input texel_t t, input logic [FACE_W-1:0] face,
		input logic [STEP_W-1:0] step);
		logic [63:0]  lim;
		logic [63:0]  m2;
		logic [63:0]  f;
		logic [63:0]  k;
		logic [63:0]  y;
		logic [63:0]  y2r;
		logic [63:0]  r3;
		logic [63:0]  mag;
		logic [63:0]  hi;
		logic [127:0] wide;
		logic         e;
		logic         neg;
		int           sh;
		weighted_t    res;
		lim = (face < FACE_W'(MAX_FACE_SIZE)) ? 64'(face) : 64'(MAX_FACE_SIZE);
		res.coord_error = 1'b0;
		if (64'(t.col) >= lim || 64'(t.row) >= lim) begin
			res.weighted_value = '0;
			res.coord_error    = 1'b1;
			return res;
		end
		// Squared radius, normalised into [1.0, 4.0) with an exponent bit.
		m2 = coord_square(t.col, step) + coord_square(t.row, step) + (64'd1 << 30);
		e  = (m2 >= (64'd1 << 32));
		f  = e ? (m2 >> 2) : m2;
		k  = (f >> 26) & 64'd63;
		// Table seed, then two refinements and the cube.
		y   = isqrt_floor((64'd1 << 59) / (2 * k + 1)) << 3;
		y   = newton_step(y, f);
		y   = newton_step(y, f);
		y2r = (y * y + (64'd1 << 29)) >> 30;
		r3  = (y2r * y + (64'd1 << 29)) >> 30;
		// Scale the magnitude, round half away from zero and saturate.
		neg  = t.value[VALUE_W-1];
		mag  = neg ? (64'd1 << 32) - {32'd0, t.value} : {32'd0, t.value};
		sh   = e ? 93 : 90;
		wide = {64'd0, {32'd0, step} * {32'd0, step}} * {64'd0, mag * r3};
		hi   = wide[127:64] + (64'd1 << (sh - 65));
		mag  = hi >> (sh - 64);
		if (neg) begin
			if (mag > 64'h8000_0000) mag = 64'h8000_0000;
			res.weighted_value = 32'((64'd1 << 32) - mag);
		end else begin
			if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
			res.weighted_value = mag[31:0];
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
		end
	endtask

	// Texel driver: presents the next queued texel, with random gaps.
	always @(negedge clk) begin : drive_texels
		texel_t t;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (texel_queue.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
				t = texel_queue.pop_front();
				in_valid     <= 1'b1;
				texel_col    <= t.col;
				texel_row    <= t.row;
				sample_value <= t.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure plus long hold-offs on request.
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_requests;
			stall_left   <= LONG_STALL;
			out_ready    <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Monitor: checks each result transaction, then predicts each accepted texel.
	always @(posedge clk) begin : monitor
		weighted_t want;
		texel_t    t;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pending_weights.size() == 0) begin
					note_mismatch("unrequested result", '0, weighted_value);
				end else begin
					want = pending_weights.pop_front();
					if (weighted_value !== want.weighted_value) begin
						note_mismatch("weighted_value", want.weighted_value, weighted_value);
					end
					if (coord_error !== want.coord_error) begin
						note_mismatch("coord_error", 32'(want.coord_error), 32'(coord_error));
					end
				end
			end
			if (in_valid && in_ready) begin
				t.col   = texel_col;
				t.row   = texel_row;
				t.value = sample_value;
				pending_weights.push_back(weigh_texel(t, model_face, model_step));
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_FACE_SIZE:  model_face = FACE_W'(data);
			REG_TEXEL_STEP: model_step = STEP_W'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] face, input logic [CFG_DATA_W-1:0] step);
		write_reg(REG_FACE_SIZE, face);
		write_reg(REG_TEXEL_STEP, step);
	endtask

	task automatic push_texel(input int col, input int row, input logic [VALUE_W-1:0] value);
		texel_t t;
		t.col   = COORD_W'(col);
		t.row   = COORD_W'(row);
		t.value = value;
		texel_queue.push_back(t);
	endtask

	// Random texels, mostly inside the face, with edges and extreme values favoured.
	task automatic push_random(input int count);
		texel_t t;
		int     lim;
		@(posedge clk);
		lim = (model_face < FACE_W'(MAX_FACE_SIZE)) ? int'(model_face) : MAX_FACE_SIZE;
		for (int i = 0; i < count; i++) begin
			if (lim == 0 || $urandom_range(9) == 0) begin
				t.col = COORD_W'($urandom);
				t.row = COORD_W'($urandom);
			end else begin
				t.col = COORD_W'($urandom_range(lim - 1, 0));
				t.row = COORD_W'($urandom_range(lim - 1, 0));
				if ($urandom_range(7) == 0) t.col = COORD_W'(lim - 1);
				if ($urandom_range(7) == 0) t.row = '0;
			end
			case ($urandom_range(9))
				0: t.value = 32'h7FFF_FFFF;
				1: t.value = 32'h8000_0000;
				2: t.value = 32'(int'($urandom_range(1 << 18, 0)) - (1 << 17));
				default: t.value = $urandom;
			endcase
			texel_queue.push_back(t);
		end
	endtask

	// Waits until every queued texel has been sent and every predicted result has arrived.
	task automatic wait_drained();
		while (texel_queue.size() != 0 || in_valid || pending_weights.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : run_phases
		logic [CFG_DATA_W-1:0] face;
		logic [CFG_DATA_W-1:0] step;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: corners, centre, face edge and value extremes.
		@(posedge clk);
		push_texel(0, 0, 32'h7FFF_FFFF);
		push_texel(63, 63, 32'h8000_0000);
		push_texel(0, 63, 32'h0000_0000);
		push_texel(63, 0, 32'h0000_0001);
		push_texel(31, 32, 32'hFFFF_FFFF);
		push_texel(32, 31, 32'h0001_0000);
		push_texel(0, 0, 32'hFFFF_0000);
		push_texel(64, 0, 32'h0001_0000);
		push_texel(0, 64, 32'h0001_0000);
		push_texel(4095, 4095, 32'h7FFF_FFFF);
		push_texel(4095, 0, 32'h0001_0000);
		wait_drained();

		// Single-texel face: the weight is 4, so large values saturate both ways.
		configure(32'd1, 32'h8000_0000);
		@(posedge clk);
		push_texel(0, 0, 32'h7FFF_FFFF);
		push_texel(0, 0, 32'h8000_0000);
		push_texel(0, 0, 32'h0001_0000);
		push_texel(1, 0, 32'h0001_0000);
		push_texel(0, 1, 32'h0001_0000);
		wait_drained();

		// Zero face size flags every texel; writes to undecoded indexes change nothing.
		write_reg(REG_FACE_SIZE, 32'd0);
		write_reg(REG_SPARE_A, 32'd0);
		write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
		@(posedge clk);
		push_texel(0, 0, 32'h0001_0000);
		push_texel(4095, 4095, 32'h8000_0000);
		push_random(20);
		wait_drained();

		// Oversized face and the largest step: coordinates saturate.
		configure(32'd8191, 32'hFFFF_FFFF);
		push_random(60);
		wait_drained();

		// Zero step gives zero weight everywhere.
		configure(32'd16, 32'd0);
		push_random(40);
		wait_drained();

		// Largest honoured face, with no idling on either side.
		idle_on = 1'b0;
		configure(32'd4096, 32'h0008_0000);
		push_random(400);
		wait_drained();
		idle_on = 1'b1;

		// Long receiver hold-off while the sender keeps offering texels.
		configure(32'd64, 32'h0200_0000);
		push_random(300);
		stall_requests++;
		wait_drained();

		// Random faces with nominal, perturbed or arbitrary steps.
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(3))
				0: face = $urandom_range(8, 1);
				1: face = $urandom_range(4096, 1);
				2: face = 32'd4096;
				default: face = $urandom_range(200, 9);
			endcase
			case ($urandom_range(3))
				0, 1: step = 32'((64'd1 << 31) / face);
				2: step = 32'((64'd1 << 31) / face) + $urandom_range(2047, 0) - 32'd1024;
				default: step = $urandom;
			endcase
			configure(face, step);
			push_random(60);
			wait_drained();
		end

		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
